// ===== hdl/kpsd_pkg.sv =====
// Shared types, constants and tables for the keypad scanner / digit display.
// No dependencies.
package kpsd_pkg;

  localparam int SEG_W   = 7;
  localparam int COL_W   = 4;
  localparam int ROW_W   = 2;
  localparam int ROWS    = 4;
  localparam int KEY_W   = 4;
  localparam int CNT_W   = 20;
  localparam int EN_W    = 4;
  localparam int IN_TW   = 8;
  localparam int OUT_TW  = 16;

  localparam logic [CNT_W-1:0] SCANS_RESET = 20'd20000;

  // single-column-low codes
  localparam logic [COL_W-1:0] COL0_LOW = 4'hE;
  localparam logic [COL_W-1:0] COL1_LOW = 4'hD;
  localparam logic [COL_W-1:0] COL2_LOW = 4'hB;

  localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;

  typedef struct packed {
    logic             hit;
    logic [SEG_W-1:0] seg;
  } key_dec_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [KEY_W-1:0] key);
    logic [SEG_W-1:0] s;
    unique case (key)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [SEG_W-1:0] store_init(input int idx);
    logic [SEG_W-1:0] s;
    unique case (idx)
      0:       s = 7'h07;
      1:       s = 7'h7D;
      2:       s = 7'h3F;
      3:       s = 7'h4F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/kpsd_decode.sv =====
// Keypad sample decode: row plus column sense to key hit and segment pattern.
// Depends on kpsd_pkg.
module kpsd_decode (
  input  logic [kpsd_pkg::ROW_W-1:0] row,
  input  logic [kpsd_pkg::COL_W-1:0] cols,
  output kpsd_pkg::key_dec_t         dec
);
  import kpsd_pkg::*;

  logic             col_ok;
  logic [1:0]       col;
  logic [KEY_W-1:0] key;

  always_comb begin
    col_ok = 1'b1;
    col    = 2'd0;
    unique case (cols)
      COL0_LOW: col = 2'd0;
      COL1_LOW: col = 2'd1;
      COL2_LOW: col = 2'd2;
      default:  col_ok = 1'b0;
    endcase

    key     = {2'b00, row} * 4'd3 + {2'b00, col} + 4'd1;
    dec.hit = 1'b0;
    if (col_ok) begin
      if (row != LAST_ROW) begin
        dec.hit = 1'b1;
      end else if (col == 2'd1) begin
        dec.hit = 1'b1;
        key     = 4'd0;
      end
    end
    dec.seg = seg_of(key);
  end

endmodule

// ===== hdl/kpsd_display.sv =====
// Display phase select: picks digit pattern and enable for the current phase; odd phases are blank.
// Depends on kpsd_pkg.
module kpsd_display #(
  parameter int DIGITS = 4,
  parameter int PH_W   = 3
) (
  input  logic [PH_W-1:0]            phase,
  input  logic [kpsd_pkg::SEG_W-1:0] store [DIGITS],
  output logic [kpsd_pkg::SEG_W-1:0] segments,
  output logic [kpsd_pkg::EN_W-1:0]  digit_enable
);
  import kpsd_pkg::*;

  always_comb begin
    segments     = '0;
    digit_enable = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (phase == PH_W'(2 * i)) begin
        segments     = store[i];
        digit_enable = EN_W'(1) << i;
      end
    end
  end

endmodule

// ===== hdl/keypad_scan_digit_display.sv =====
// Top level: keypad row scanner, digit shift store and display phase sequencer.
// Depends on kpsd_pkg, kpsd_decode, kpsd_display.
//
// Usage:
//   in_*  : one beat per column sample, tdata[3:0] = column_sense (active low)
//           taken while the row from the previous out beat is driven.
//   out_* : one beat per input beat, tdata from bit 0 up = row_drive[3:0],
//           segments[6:0], digit_enable[3:0], key_accepted.
//   cfg_* : cfg_wr_en writes scans_per_phase (zero acts as one); write it
//           only while no beat is in flight.
// The out beat appears in the cycle after its in beat is taken. Throughput is one
// beat per cycle while the receiver does not stall: decode, store shift and counter
// update all sit between the input handshake and the output register.
// Reset clears scan and display state, loads the startup digit patterns and
// sets scans_per_phase to 20000; no out beat is pending after reset.
// When the receiver stalls, the out register holds its beat and in_tready
// drops, so no sample is taken and state does not advance.
module keypad_scan_digit_display #(
  parameter int DIGITS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [kpsd_pkg::IN_TW-1:0]  in_tdata,   // column_sense[3:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // row_drive[3:0], segments[10:4], digit_enable[14:11], key_accepted[15]
  output logic [kpsd_pkg::OUT_TW-1:0] out_tdata,
  input  logic                        cfg_wr_en,
  input  logic [kpsd_pkg::CNT_W-1:0]  cfg_wr_data
);
  import kpsd_pkg::*;

  localparam int PHASES = 2 * DIGITS;
  localparam int PH_W   = $clog2(PHASES);

  logic [CNT_W-1:0] scans_r;
  logic [SEG_W-1:0] store_r [DIGITS];
  logic [SEG_W-1:0] store_nxt [DIGITS];
  logic             held_r, held_nxt;
  logic             seen_r, seen_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc, limit;
  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [PH_W:0]    phase_inc;
  logic             out_valid_r;
  logic [OUT_TW-1:0] out_data_r, out_data_nxt;
  logic             accept;
  logic             shift;
  key_dec_t         dec;
  logic [SEG_W-1:0] seg;
  logic [EN_W-1:0]  en;
  logic [ROWS-1:0]  row_drive;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  kpsd_decode u_decode (
    .row  (row_r),
    .cols (in_tdata[COL_W-1:0]),
    .dec  (dec)
  );

  always_comb begin
    shift    = dec.hit && !held_r;
    held_nxt = held_r || dec.hit;
    seen_nxt = seen_r || dec.hit;
    cnt_nxt  = cnt_r;
    phase_nxt = phase_r;
    limit    = (scans_r == '0) ? CNT_W'(1) : scans_r;
    cnt_inc  = cnt_r + CNT_W'(1);
    phase_inc = {1'b0, phase_r} + (PH_W + 1)'(1);

    if (row_r == LAST_ROW) begin
      if (!seen_nxt) begin
        held_nxt = 1'b0;
      end
      seen_nxt = 1'b0;
      cnt_nxt  = cnt_inc;
      if (cnt_inc >= limit) begin
        cnt_nxt = '0;
        if (phase_inc >= (PH_W + 1)'(PHASES)) begin
          phase_nxt = '0;
        end else begin
          phase_nxt = phase_inc[PH_W-1:0];
        end
      end
    end
    row_nxt = row_r + ROW_W'(1);

    for (int i = 0; i < DIGITS; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (shift) begin
      store_nxt[0] = dec.seg;
      for (int i = 1; i < DIGITS; i++) begin
        store_nxt[i] = store_r[i-1];
      end
    end
  end

  kpsd_display #(
    .DIGITS (DIGITS),
    .PH_W   (PH_W)
  ) u_display (
    .phase        (phase_nxt),
    .store        (store_nxt),
    .segments     (seg),
    .digit_enable (en)
  );

  assign row_drive    = ~(ROWS'(1) << row_nxt);
  assign out_data_nxt = {shift, en, seg, row_drive};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scans_r     <= SCANS_RESET;
      held_r      <= 1'b0;
      seen_r      <= 1'b0;
      row_r       <= '0;
      cnt_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        store_r[i] <= store_init(i);
      end
    end else begin
      if (cfg_wr_en) begin
        scans_r <= cfg_wr_data;
      end
      if (accept) begin
        held_r      <= held_nxt;
        seen_r      <= seen_nxt;
        row_r       <= row_nxt;
        cnt_r       <= cnt_nxt;
        phase_r     <= phase_nxt;
        out_valid_r <= 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
          store_r[i] <= store_nxt[i];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== tb/keypad_scan_digit_display_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for keypad_scan_digit_display: scan/display predictor and stream drivers.
// Depends on kpsd_pkg and the keypad_scan_digit_display RTL.
module keypad_scan_digit_display_test;

  localparam logic [kpsd_pkg::COL_W-1:0] COLS_IDLE = 4'hF;
  localparam int                         HOLD_OFF_CYCLES = 48;

  typedef struct packed {
    logic                        key_accepted;
    logic [kpsd_pkg::EN_W-1:0]   digit_enable;
    logic [kpsd_pkg::SEG_W-1:0]  segments;
    logic [kpsd_pkg::COL_W-1:0]  row_drive;
  } disp_beat_t;

  class keypad_scoreboard;
    logic [kpsd_pkg::SEG_W-1:0] glyph [10];
    logic [kpsd_pkg::SEG_W-1:0] shown [4];
    bit                         held;
    bit                         seen_this_scan;
    bit [1:0]                   row;
    bit [kpsd_pkg::CNT_W-1:0]   scan_cnt;
    bit [kpsd_pkg::CNT_W-1:0]   scans_per_phase;
    bit [2:0]                   phase;
    disp_beat_t                 frames [$];
    int                         mismatches;
    int                         beats_checked;
    int                         keys_taken;
    bit [7:0]                   phases_seen;

    function new();
      glyph = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
      shown = '{7'h07, 7'h7D, 7'h3F, 7'h4F};
      scans_per_phase = kpsd_pkg::SCANS_RESET;
      phases_seen = 8'h01;
    endfunction

    function void set_scans(bit [kpsd_pkg::CNT_W-1:0] v);
      scans_per_phase = v;
    endfunction

    function int pending();
      return frames.size();
    endfunction

    function void note_sample(logic [kpsd_pkg::COL_W-1:0] cols);
      int                       c;
      int                       key;
      int                       i;
      bit [kpsd_pkg::CNT_W-1:0] limit;
      disp_beat_t               beat;
      key = -1;
      beat = '0;
      limit = (scans_per_phase == 0) ? kpsd_pkg::CNT_W'(1) : scans_per_phase;
      case (cols)
        kpsd_pkg::COL0_LOW: c = 0;
        kpsd_pkg::COL1_LOW: c = 1;
        kpsd_pkg::COL2_LOW: c = 2;
        default:            c = -1;
      endcase
      if (c >= 0) begin
        if (row != kpsd_pkg::LAST_ROW) key = int'(row) * 3 + c + 1;
        else if (c == 1) key = 0;
      end
      if (key >= 0) begin
        if (!held) begin
          for (i = 3; i > 0; i--) shown[i] = shown[i-1];
          shown[0] = glyph[key];
          held = 1;
          beat.key_accepted = 1;
          keys_taken++;
        end
        seen_this_scan = 1;
      end
      if (row == kpsd_pkg::LAST_ROW) begin
        if (!seen_this_scan) held = 0;
        seen_this_scan = 0;
        scan_cnt++;
        if (scan_cnt >= limit) begin
          scan_cnt = 0;
          phase++;
        end
      end
      row++;
      if (!phase[0]) begin
        beat.segments = shown[phase[2:1]];
        beat.digit_enable = 4'b0001 << phase[2:1];
      end
      beat.row_drive = ~(4'b0001 << row);
      phases_seen[phase] = 1;
      frames.push_back(beat);
    endfunction

    function void check_beat(disp_beat_t got);
      disp_beat_t want;
      beats_checked++;
      if (frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("out beat %0d arrived with nothing pending: %h", beats_checked, got);
        return;
      end
      want = frames.pop_front();
      if (got.row_drive !== want.row_drive || got.segments !== want.segments ||
          got.digit_enable !== want.digit_enable || got.key_accepted !== want.key_accepted) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: want row %h seg %h en %h acc %b, got row %h seg %h en %h acc %b",
                   beats_checked, want.row_drive, want.segments, want.digit_enable,
                   want.key_accepted, got.row_drive, got.segments, got.digit_enable,
                   got.key_accepted);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [kpsd_pkg::IN_TW-1:0]    in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [kpsd_pkg::OUT_TW-1:0]   out_tdata;
  logic                          cfg_wr_en;
  logic [kpsd_pkg::CNT_W-1:0]    cfg_wr_data;

  keypad_scoreboard board;
  int  samples_sent;
  bit  calm;
  bit  tx_bursty;
  bit  rx_bursty = 1'b1;
  bit  long_hold_req;
  bit  long_hold_done;

  keypad_scan_digit_display uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_sample(in_tdata[kpsd_pkg::COL_W-1:0]);
      if (out_tvalid && out_tready) board.check_beat(out_tdata);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        long_hold_done = 1;
      end else if (!calm && rx_bursty && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
      if ($urandom_range(0, 49) == 0) rx_bursty = !rx_bursty;
    end
  end

  initial begin
    #400000;
    $display("timeout with %0d beats pending", board.pending());
    $display("[keypad_scan_digit_display] ERROR");
    $finish;
  end

  task automatic push_sample(input logic [kpsd_pkg::COL_W-1:0] cols);
    if (!calm && tx_bursty && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(kpsd_pkg::IN_TW-kpsd_pkg::COL_W){1'b0}}, cols};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    samples_sent++;
    if ($urandom_range(0, 39) == 0) tx_bursty = !tx_bursty;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_scans(input logic [kpsd_pkg::CNT_W-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_scans(v);
  endtask

  // key presses held over a few scans with bounce noise, then releases; some pure noise
  task automatic run_presses(input int n);
    int                         start;
    int                         k;
    int                         krow;
    int                         len;
    int                         j;
    logic [kpsd_pkg::COL_W-1:0] kcols;
    logic [kpsd_pkg::COL_W-1:0] v;
    start = samples_sent;
    while (samples_sent - start < n) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++) push_sample(4'($urandom_range(0, 15)));
      end else begin
        k = $urandom_range(0, 9);
        krow = (k == 0) ? 3 : (k - 1) / 3;
        case ((k == 0) ? 1 : (k - 1) % 3)
          0:       kcols = kpsd_pkg::COL0_LOW;
          1:       kcols = kpsd_pkg::COL1_LOW;
          default: kcols = kpsd_pkg::COL2_LOW;
        endcase
        len = $urandom_range(4, 12);
        for (j = 0; j < len; j++) begin
          if (samples_sent % 4 == krow)
            v = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : kcols;
          else
            v = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : COLS_IDLE;
          push_sample(v);
        end
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 9);
        for (j = 0; j < len; j++) push_sample(COLS_IDLE);
      end
    end
  endtask

  initial begin
    logic [kpsd_pkg::COL_W-1:0] directed [24];
    int                         i;
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    tx_bursty = 1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // rows go 0,1,2,3 per sample: press 1, held press 2 and row 3 dead keys,
    // no-key/multi-key scan that clears held, press 0, held 6, held 7
    directed = '{kpsd_pkg::COL0_LOW, COLS_IDLE, COLS_IDLE, COLS_IDLE,
                 kpsd_pkg::COL1_LOW, 4'h0, COLS_IDLE, kpsd_pkg::COL0_LOW,
                 COLS_IDLE, 4'h7, 4'h9, kpsd_pkg::COL2_LOW,
                 COLS_IDLE, COLS_IDLE, COLS_IDLE, kpsd_pkg::COL1_LOW,
                 COLS_IDLE, kpsd_pkg::COL2_LOW, COLS_IDLE, COLS_IDLE,
                 COLS_IDLE, COLS_IDLE, kpsd_pkg::COL0_LOW, 4'h3};
    for (i = 0; i < 24; i++) push_sample(directed[i]);

    write_scans(20'd1);
    run_presses(100);
    long_hold_req = 1;
    run_presses(200);
    write_scans(20'd0);
    run_presses(200);
    write_scans(20'd3);
    run_presses(120);
    wait_idle();
    run_presses(130);
    write_scans(20'hFFFFF);
    run_presses(150);
    write_scans(20'd2);
    run_presses(100);
    calm = 1;
    run_presses(200);

    in_tvalid <= 1'b0;
    for (i = 0; i < 500 && board.pending() != 0; i++) @(negedge clk);
    repeat (4) @(negedge clk);
    if (board.pending() != 0) begin
      $display("%0d beats never arrived", board.pending());
      board.mismatches++;
    end

    $display("%0d column samples, %0d out beats checked, %0d digits shifted in",
             samples_sent, board.beats_checked, board.keys_taken);
    $display("display phases reached %b under scan settings 20000, 1, 0, 3, 1048575, 2",
             board.phases_seen);
    if (board.mismatches == 0)
      $display("[keypad_scan_digit_display] OK");
    else
      $display("[keypad_scan_digit_display] ERROR");
    $finish;
  end

endmodule

// ===== keypad_scan_digit_display.f =====
hdl/kpsd_pkg.sv
hdl/kpsd_decode.sv
hdl/kpsd_display.sv
hdl/keypad_scan_digit_display.sv
tb/keypad_scan_digit_display_test.sv
